FILE: sv/hfl_pkg.sv
// ----------------------------------------------------------------------------
// hfl_pkg
// shared types, codes and constants of the three-state forward likelihood block
// ----------------------------------------------------------------------------
package hfl_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_BITS      = 20;
	localparam int EXP_MAX       = 4095;
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 34;
	localparam int PAR_W      = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURV_NB   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SURV_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_NB   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_B    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_NB = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_B  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ASCERTAIN = 3'd7;

	localparam logic [PAR_W-1:0]      PAR_RESET = 17'd32768;
	localparam logic [CFG_DATA_W-1:0] ASC_RESET = 34'd2147516416;

	// observation codes
	localparam logic [1:0] OBS_UNSEEN = 2'd0;
	localparam logic [1:0] OBS_NB     = 2'd1;
	localparam logic [1:0] OBS_B      = 2'd2;
	localparam logic [1:0] OBS_NA     = 2'd3;

	// sequencer steps, also the controller state codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_IDLE  = 4'd0;
	localparam logic [OP_W-1:0] OP_MAT   = 4'd1;
	localparam logic [OP_W-1:0] OP_START = 4'd2;
	localparam logic [OP_W-1:0] OP_MAC   = 4'd3;
	localparam logic [OP_W-1:0] OP_SCL   = 4'd4;
	localparam logic [OP_W-1:0] OP_NMAX  = 4'd5;
	localparam logic [OP_W-1:0] OP_NMSB  = 4'd6;
	localparam logic [OP_W-1:0] OP_NSHF  = 4'd7;
	localparam logic [OP_W-1:0] OP_LSUM  = 4'd8;
	localparam logic [OP_W-1:0] OP_LINIT = 4'd9;
	localparam logic [OP_W-1:0] OP_LSQ   = 4'd10;
	localparam logic [OP_W-1:0] OP_LMUL  = 4'd11;

	localparam int CNT_W = 5;

	typedef struct packed {
		logic [1:0] obs_code;
		logic       start_flag;
		logic       last_flag;
	} obs_t;

	typedef struct packed {
		logic [39:0] ind_nll;
		logic [47:0] total_nll;
		logic        sum_zero;
	} res_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] cnt;
		logic             start;
		logic             accept;
		logic             fire;
	} cmd_t;

	typedef struct packed {
		logic sum_zero;
	} status_t;

endpackage

FILE: sv/hfl_ctrl.sv
// ----------------------------------------------------------------------------
// hfl_ctrl
// step sequencer: walks one occasion through the shared multiplier schedule
// ----------------------------------------------------------------------------
module hfl_ctrl import hfl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    obs_valid,
	output logic    obs_ready,
	input  logic    start_flag,
	input  logic    last_flag,
	output logic    res_valid,
	input  logic    res_ready,
	input  status_t status,
	output cmd_t    cmd
);

	logic [OP_W-1:0]  state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             start_q, last_q, res_valid_q;
	logic             accept, fire;

	assign obs_ready = (state_q == OP_IDLE);
	assign accept    = obs_valid && obs_ready;
	assign fire      = (state_q == OP_LMUL) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 1'b1;
		unique case (state_q)
			OP_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					state_d = start_flag ? OP_START : OP_MAT;
				end
			end
			OP_MAT: begin
				if (cnt_q == CNT_W'(5)) begin
					state_d = OP_MAC;
					cnt_d   = '0;
				end
			end
			OP_MAC: begin
				if (cnt_q == CNT_W'(8)) begin
					state_d = OP_SCL;
					cnt_d   = '0;
				end
			end
			OP_SCL: begin
				if (cnt_q == CNT_W'(2)) begin
					state_d = OP_NMAX;
					cnt_d   = '0;
				end
			end
			OP_START: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = OP_NMAX;
					cnt_d   = '0;
				end
			end
			OP_NMAX: state_d = OP_NMSB;
			OP_NMSB: state_d = OP_NSHF;
			OP_NSHF: state_d = last_q ? OP_LSUM : OP_IDLE;
			OP_LSUM: state_d = OP_LINIT;
			OP_LINIT: begin
				cnt_d   = '0;
				state_d = status.sum_zero ? OP_LMUL : OP_LSQ;
			end
			OP_LSQ: begin
				if (cnt_q == CNT_W'(LOG_BITS - 1)) begin
					state_d = OP_LMUL;
					cnt_d   = '0;
				end
			end
			OP_LMUL: begin
				if (fire) begin
					state_d = OP_IDLE;
				end
			end
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= OP_IDLE;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (accept) begin
				start_q <= start_flag;
				last_q  <= last_flag;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.op     = state_q;
	assign cmd.cnt    = cnt_q;
	assign cmd.start  = start_q;
	assign cmd.accept = accept;
	assign cmd.fire   = fire;

endmodule

FILE: sv/hfl_datapath.sv
// ----------------------------------------------------------------------------
// hfl_datapath
// config registers, shared multiplier, forward vector, normaliser and log unit
// ----------------------------------------------------------------------------
module hfl_datapath import hfl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            obs_code,
	input  cmd_t                  cmd,
	output status_t               status,
	output res_t                  res
);

	localparam int PW = FRAC_BITS + 1;
	localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	function automatic logic [PW-1:0] prob(input logic [PAR_W-1:0] r);
		logic [31:0] rx;
		rx = 32'(r);
		return (rx > 32'(ONE)) ? ONE : rx[PW-1:0];
	endfunction

	// config
	logic [PAR_W-1:0]      init_q, snb_q, sb_q, mnb_q, mb_q, dnb_q, db_q;
	logic [CFG_DATA_W-1:0] asc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= PAR_RESET;
			snb_q  <= PAR_RESET;
			sb_q   <= PAR_RESET;
			mnb_q  <= PAR_RESET;
			mb_q   <= PAR_RESET;
			dnb_q  <= PAR_RESET;
			db_q   <= PAR_RESET;
			asc_q  <= ASC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INIT:      init_q <= cfg_data[PAR_W-1:0];
				REG_SURV_NB:   snb_q  <= cfg_data[PAR_W-1:0];
				REG_SURV_B:    sb_q   <= cfg_data[PAR_W-1:0];
				REG_MOVE_NB:   mnb_q  <= cfg_data[PAR_W-1:0];
				REG_MOVE_B:    mb_q   <= cfg_data[PAR_W-1:0];
				REG_DETECT_NB: dnb_q  <= cfg_data[PAR_W-1:0];
				REG_DETECT_B:  db_q   <= cfg_data[PAR_W-1:0];
				REG_ASCERTAIN: asc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [PW-1:0] pi, snb, sb, mnb, mb, dnb, db, anb, ab;
	assign pi  = prob(init_q);
	assign snb = prob(snb_q);
	assign sb  = prob(sb_q);
	assign mnb = prob(mnb_q);
	assign mb  = prob(mb_q);
	assign dnb = prob(dnb_q);
	assign db  = prob(db_q);
	assign anb = prob(asc_q[PAR_W-1:0]);
	assign ab  = prob(asc_q[2*PAR_W-1:PAR_W]);

	// working registers
	logic [1:0]    code_q;
	logic [PW-1:0] a_q [4];
	logic [PW-1:0] b_q [2];
	logic [31:0]   fwd_q [3];
	logic [11:0]   exp_q;
	logic [47:0]   tot_q;
	logic [65:0]   acc_q;
	logic [33:0]   t_q [3];
	logic [65:0]   u_q [3];
	logic [65:0]   m_q;
	logic [6:0]    p_q;
	logic          mz_q;
	logic [33:0]   sum_q;
	logic          sz_q;
	logic [5:0]    lp_q;
	logic [30:0]   x_q;
	logic [LOG_BITS-1:0] frac_q;

	// shared multiplier
	logic [33:0] mul_a;
	logic [31:0] mul_b;
	logic [65:0] prod;
	assign prod = 66'(mul_a) * 66'(mul_b);

	logic [PW-1:0] fprod;
	assign fprod = PW'(prod >> FRAC_BITS);

	// mac indexes
	logic [1:0] mj, mk;
	always_comb begin
		case (cmd.cnt)
			5'd0:    begin mj = 2'd0; mk = 2'd0; end
			5'd1:    begin mj = 2'd0; mk = 2'd1; end
			5'd2:    begin mj = 2'd0; mk = 2'd2; end
			5'd3:    begin mj = 2'd1; mk = 2'd0; end
			5'd4:    begin mj = 2'd1; mk = 2'd1; end
			5'd5:    begin mj = 2'd1; mk = 2'd2; end
			5'd6:    begin mj = 2'd2; mk = 2'd0; end
			5'd7:    begin mj = 2'd2; mk = 2'd1; end
			default: begin mj = 2'd2; mk = 2'd2; end
		endcase
	end

	logic [PW-1:0] a_sel;
	always_comb begin
		a_sel = '0;
		case (mk)
			2'd0:    a_sel = (mj == 2'd0) ? a_q[0] : (mj == 2'd1) ? a_q[1] : snb;
			2'd1:    a_sel = (mj == 2'd0) ? a_q[2] : (mj == 2'd1) ? a_q[3] : sb;
			default: a_sel = (mj == 2'd2) ? ONE : '0;
		endcase
	end

	logic [PW-1:0] bo2;
	assign bo2 = (code_q == OBS_UNSEEN) ? ONE : '0;

	logic [1:0] sj;
	assign sj = cmd.cnt[1:0];

	// first-encounter weights
	logic [PW-1:0] be0, be1;
	assign be0 = (code_q == OBS_NB) ? ONE - anb : (code_q == OBS_NA) ? anb : '0;
	assign be1 = (code_q == OBS_B)  ? ONE - ab  : (code_q == OBS_NA) ? ab  : '0;

	// log step and final scaling
	logic [31:0]  sq;
	logic signed [14:0] ld;
	logic signed [34:0] lv;
	logic [31:0]  lc;
	assign sq = prod[61:30];
	assign ld = $signed({3'b0, exp_q}) - $signed({9'b0, lp_q});
	assign lv = ($signed({{20{ld[14]}}, ld}) <<< LOG_BITS)
		- $signed({15'b0, frac_q});
	assign lc = lv[34] ? 32'd0 : lv[31:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MAT: begin
				case (cmd.cnt)
					5'd0: begin mul_a = 34'(ONE - snb); mul_b = 32'(mnb); end
					5'd1: begin mul_a = 34'(ONE - snb); mul_b = 32'(ONE - mnb); end
					5'd2: begin mul_a = 34'(ONE - sb);  mul_b = 32'(ONE - mb); end
					5'd3: begin mul_a = 34'(ONE - sb);  mul_b = 32'(mb); end
					5'd4: begin
						mul_a = 34'(ONE - dnb);
						mul_b = (code_q == OBS_NB) ? 32'(ONE - anb) : 32'(anb);
					end
					default: begin
						mul_a = 34'(ONE - db);
						mul_b = (code_q == OBS_B) ? 32'(ONE - ab) : 32'(ab);
					end
				endcase
			end
			OP_START: begin
				mul_a = (cmd.cnt == 5'd0) ? 34'(ONE - pi) : 34'(pi);
				mul_b = (cmd.cnt == 5'd0) ? 32'(be0) : 32'(be1);
			end
			OP_MAC: begin
				mul_a = 34'(fwd_q[mk]);
				mul_b = 32'(a_sel);
			end
			OP_SCL: begin
				mul_a = t_q[sj];
				mul_b = (sj == 2'd0) ? 32'(b_q[0]) : (sj == 2'd1) ? 32'(b_q[1]) : 32'(bo2);
			end
			OP_LSQ: begin
				mul_a = 34'(x_q);
				mul_b = 32'(x_q);
			end
			OP_LMUL: begin
				mul_a = 34'(lc);
				mul_b = LN2_Q32;
			end
			default: ;
		endcase
	end

	// normaliser pieces
	logic [65:0] mx;
	assign mx = (u_q[1] > u_q[0]) ? ((u_q[2] > u_q[1]) ? u_q[2] : u_q[1])
		: ((u_q[2] > u_q[0]) ? u_q[2] : u_q[0]);

	logic [6:0] m_msb;
	always_comb begin
		m_msb = '0;
		for (int i = 0; i < 66; i++) begin
			if (m_q[i]) m_msb = 7'(i);
		end
	end

	logic signed [7:0]  s_sh;
	logic signed [14:0] ebase, enew;
	assign s_sh  = $signed({1'b0, p_q}) - 8'sd31;
	assign ebase = cmd.start ? 15'(2 * FRAC_BITS) : $signed({3'b0, exp_q}) + 15'(FRAC_BITS);
	assign enew  = ebase - 15'(s_sh);

	logic [31:0] shv [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!s_sh[7]) shv[i] = 32'(u_q[i] >> s_sh[6:0]);
			else          shv[i] = 32'(u_q[i] << 7'(-s_sh));
		end
	end

	// log unit pieces
	logic [33:0] fsum;
	assign fsum = 34'(fwd_q[0]) + 34'(fwd_q[1]) + 34'(fwd_q[2]);

	logic [5:0] s_msb;
	always_comb begin
		s_msb = '0;
		for (int i = 0; i < 34; i++) begin
			if (sum_q[i]) s_msb = 6'(i);
		end
	end

	logic [30:0] xn;
	assign xn = (s_msb >= 6'd30) ? 31'(sum_q >> (s_msb - 6'd30))
		: 31'(sum_q << (6'd30 - s_msb));

	logic [39:0] nll;
	logic [48:0] tsum;
	assign nll  = sz_q ? {40{1'b1}} : 40'(prod[65:36]);
	assign tsum = 49'(tot_q) + 49'(nll);

	always_ff @(posedge clk) begin
		if (cmd.accept) code_q <= obs_code;
		case (cmd.op)
			OP_MAT: begin
				case (cmd.cnt)
					5'd0: a_q[0] <= fprod;
					5'd1: a_q[1] <= fprod;
					5'd2: a_q[2] <= fprod;
					5'd3: a_q[3] <= fprod;
					5'd4: b_q[0] <= (code_q == OBS_UNSEEN) ? dnb
						: (code_q == OBS_B) ? '0 : fprod;
					default: b_q[1] <= (code_q == OBS_UNSEEN) ? db
						: (code_q == OBS_NB) ? '0 : fprod;
				endcase
				acc_q <= '0;
			end
			OP_START: begin
				if (cmd.cnt == 5'd0) begin
					u_q[0] <= prod;
					u_q[2] <= '0;
				end else begin
					u_q[1] <= prod;
				end
			end
			OP_MAC: begin
				if (mk == 2'd2) begin
					t_q[mj] <= 34'((acc_q + prod) >> FRAC_BITS);
					acc_q   <= '0;
				end else begin
					acc_q <= acc_q + prod;
				end
			end
			OP_SCL: u_q[sj] <= prod;
			OP_NMAX: m_q <= mx;
			OP_NMSB: begin
				p_q  <= m_msb;
				mz_q <= (m_q == '0);
			end
			OP_LSUM: begin
				sum_q <= fsum;
				sz_q  <= (fsum == '0);
			end
			OP_LINIT: begin
				lp_q   <= s_msb;
				x_q    <= xn;
				frac_q <= '0;
			end
			OP_LSQ: begin
				frac_q <= {frac_q[LOG_BITS-2:0], sq[31]};
				x_q    <= sq[31] ? sq[31:1] : sq[30:0];
			end
			OP_LMUL: begin
				if (cmd.fire) begin
					res.ind_nll   <= nll;
					res.total_nll <= tsum[48] ? {48{1'b1}} : tsum[47:0];
					res.sum_zero  <= sz_q;
				end
			end
			default: ;
		endcase
	end

	// architectural state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) fwd_q[i] <= '0;
			exp_q <= '0;
			tot_q <= '0;
		end else begin
			if (cmd.op == OP_NSHF) begin
				if (mz_q || (enew > 15'sd4095)) begin
					for (int i = 0; i < 3; i++) fwd_q[i] <= '0;
					exp_q <= '0;
				end else begin
					for (int i = 0; i < 3; i++) fwd_q[i] <= shv[i];
					exp_q <= enew[14] ? 12'd0 : enew[11:0];
				end
			end
			if (cmd.fire) begin
				tot_q <= tsum[48] ? {48{1'b1}} : tsum[47:0];
			end
		end
	end

	assign status.sum_zero = sz_q;

endmodule

FILE: sv/hmm_forward_likelihood.sv
// ----------------------------------------------------------------------------
// hmm_forward_likelihood
// three-state hidden Markov forward pass with negative log likelihood output
// ----------------------------------------------------------------------------
// Every occasion runs on one shared multiplier driven by a step sequencer, so
// items are taken one at a time. A start occasion runs through acceptance, two
// first-encounter products and three normalise steps; any other occasion runs
// through acceptance, six matrix products, nine multiply-adds, three
// observation scalings and three normalise steps. A last occasion then adds
// the log unit (sum, leading-one search, twenty squarings on the multiplier,
// final ln2 scaling), skipping the squarings when the vector sums to zero. A result
// sits in an output register until taken; the block keeps accepting items
// meanwhile and only holds on a later result if the earlier one is not taken.
// Configuration writes are always accepted and must be made while idle.
// ----------------------------------------------------------------------------
module hmm_forward_likelihood import hfl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  obs_valid,
	output logic                  obs_ready,
	input  obs_t                  obs,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// config transaction is always accepted: ready is tied high
	assign cfg_ready = 1'b1;

	hfl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.obs_valid  (obs_valid),
		.obs_ready  (obs_ready),
		.start_flag (obs.start_flag),
		.last_flag  (obs.last_flag),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.status     (status),
		.cmd        (cmd)
	);

	hfl_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.obs_code  (obs.obs_code),
		.cmd       (cmd),
		.status    (status),
		.res       (res)
	);

endmodule

FILE: sv/hfl_checker.sv
// ----------------------------------------------------------------------------
// hfl_checker
// port-level checks of the forward likelihood block
// ----------------------------------------------------------------------------
module hfl_checker import hfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic obs_valid,
	input logic obs_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// a held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one occasion at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		obs_valid && obs_ready |=> !obs_ready)
		else $error("second transaction taken while busy");

	// zero sum shows the saturated value
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sum_zero |-> res.ind_nll == {40{1'b1}})
		else $error("zero sum without saturated nll");

	// running total never below the item it includes
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.total_nll >= 48'(res.ind_nll))
		else $error("total below individual nll");

endmodule

bind hmm_forward_likelihood hfl_checker u_hfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.obs_valid (obs_valid),
	.obs_ready (obs_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives occasion sequences into the forward likelihood block under random
// handshake gaps and checks every result against a predictor or a typed-in value
// ----------------------------------------------------------------------------
module tb;
	import hfl_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint unsigned ONE = 64'd1 << FB;
	localparam longint unsigned NLL_SAT = 64'hFF_FFFF_FFFF;
	localparam longint unsigned TOT_SAT = 64'hFFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic obs_valid = 1'b0;
	logic obs_ready;
	obs_t obs = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #10 clk = ~clk;

	hmm_forward_likelihood dut (
		.clk(clk), .arst_n(arst_n),
		.obs_valid(obs_valid), .obs_ready(obs_ready), .obs(obs),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and forward state
	longint unsigned par_q[8];
	longint unsigned alpha_q[3];
	int expo_q;
	longint unsigned total_q;

	res_t pending_res[$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;

	// directed table row: item plus an optional typed-in result
	typedef struct {
		obs_t item;
		bit   fixed;
		res_t want;
	} row_t;

	function automatic longint unsigned clip_prob(longint unsigned r);
		r &= 64'h1FFFF;
		return (r > ONE) ? ONE : r;
	endfunction

	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		return (a * b) >> FB;
	endfunction

	function automatic int top_bit(longint unsigned v);
		int p;
		p = -1;
		while (v != 0) begin
			v >>= 1;
			p++;
		end
		return p;
	endfunction

	task automatic renorm(input longint unsigned u[3], input int e);
		longint unsigned m;
		int s;
		m = u[0];
		if (u[1] > m) m = u[1];
		if (u[2] > m) m = u[2];
		if (m == 0) begin
			alpha_q = '{0, 0, 0};
			expo_q = 0;
			return;
		end
		s = top_bit(m) - 31;
		for (int i = 0; i < 3; i++)
			alpha_q[i] = (s >= 0) ? (u[i] >> s) : (u[i] << (-s));
		e -= s;
		if (e > EXP_MAX) begin
			alpha_q = '{0, 0, 0};
			e = 0;
		end
		if (e < 0) e = 0;
		expo_q = e;
	endtask

	function automatic longint unsigned neg_ln(output bit zero);
		longint unsigned sum, x, frac, nll;
		longint l;
		int p;
		frac = 0;
		zero = 1'b0;
		sum = alpha_q[0] + alpha_q[1] + alpha_q[2];
		if (sum == 0) begin
			zero = 1'b1;
			return NLL_SAT;
		end
		p = top_bit(sum);
		x = (p >= 30) ? (sum >> (p - 30)) : (sum << (30 - p));
		for (int i = 0; i < LOG_BITS; i++) begin
			x = (x * x) >> 30;
			frac <<= 1;
			if (x >= (64'd2 << 30)) begin
				x >>= 1;
				frac |= 1;
			end
		end
		l = (longint'(expo_q) - p) * (longint'(1) << LOG_BITS) - longint'(frac);
		if (l < 0) l = 0;
		nll = (longint'(l) * longint'(LN2_Q32)) >> (LOG_BITS + 32 - 16);
		return (nll > NLL_SAT) ? NLL_SAT : nll;
	endfunction

	// advance the predictor by one occasion, produce a result on a last occasion
	task automatic forward_step(input obs_t it, output bit made, output res_t r);
		longint unsigned pi, snb, sb, mnb, mb, dnb, db, anb, ab, t, nll;
		longint unsigned a[3][3], bo[4][3], be[4][3], u[3];
		bit zero;
		pi = clip_prob(par_q[REG_INIT]);
		snb = clip_prob(par_q[REG_SURV_NB]);
		sb = clip_prob(par_q[REG_SURV_B]);
		mnb = clip_prob(par_q[REG_MOVE_NB]);
		mb = clip_prob(par_q[REG_MOVE_B]);
		dnb = clip_prob(par_q[REG_DETECT_NB]);
		db = clip_prob(par_q[REG_DETECT_B]);
		anb = clip_prob(par_q[REG_ASCERTAIN]);
		ab = clip_prob(par_q[REG_ASCERTAIN] >> 17);
		a[0] = '{qmul(ONE - snb, mnb), qmul(ONE - snb, ONE - mnb), snb};
		a[1] = '{qmul(ONE - sb, ONE - mb), qmul(ONE - sb, mb), sb};
		a[2] = '{0, 0, ONE};
		bo[OBS_UNSEEN] = '{dnb, db, ONE};
		bo[OBS_NB] = '{qmul(ONE - dnb, ONE - anb), 0, 0};
		bo[OBS_B] = '{0, qmul(ONE - db, ONE - ab), 0};
		bo[OBS_NA] = '{qmul(ONE - dnb, anb), qmul(ONE - db, ab), 0};
		be[OBS_UNSEEN] = '{0, 0, ONE};
		be[OBS_NB] = '{ONE - anb, 0, 0};
		be[OBS_B] = '{0, ONE - ab, 0};
		be[OBS_NA] = '{anb, ab, 0};
		if (it.start_flag) begin
			u[0] = (ONE - pi) * be[it.obs_code][0];
			u[1] = pi * be[it.obs_code][1];
			u[2] = 0;
			renorm(u, 2 * FB);
		end else begin
			for (int j = 0; j < 3; j++) begin
				t = 0;
				for (int k = 0; k < 3; k++) t += alpha_q[k] * a[k][j];
				t >>= FB;
				u[j] = t * bo[it.obs_code][j];
			end
			renorm(u, expo_q + FB);
		end
		made = it.last_flag;
		r = '0;
		if (made) begin
			nll = neg_ln(zero);
			total_q += nll;
			if (total_q > TOT_SAT) total_q = TOT_SAT;
			r.ind_nll = nll[39:0];
			r.total_nll = total_q[47:0];
			r.sum_zero = zero;
		end
	endtask

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	// valid stays up after acceptance so a zero gap gives back-to-back items
	task automatic send_item(input obs_t it);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			obs_valid <= 1'b0;
			idle_cycles(gap);
		end
		obs_valid <= 1'b1;
		obs <= it;
		@(posedge clk);
		while (!obs_ready) @(posedge clk);
	endtask

	// predict and drive one occasion; a typed-in result replaces the prediction
	task automatic occasion(input obs_t it, input bit fixed, input res_t want);
		bit made;
		res_t r;
		forward_step(it, made, r);
		if (made) pending_res.push_back(fixed ? want : r);
		send_item(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		par_q[idx] = (idx == REG_ASCERTAIN) ? (v & 64'h3_FFFF_FFFF) : (v & 64'h1FFFF);
		@(posedge clk);
	endtask

	// drop valid, drain results, then let an item without a result finish
	task automatic settle();
		obs_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		idle_cycles(60);
	endtask

	function automatic longint unsigned pick_par();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return ONE;
			2: return 64'h1FFFF;
			default: return 64'($urandom_range(0, 32'h1FFFF));
		endcase
	endfunction

	task automatic random_config();
		for (int i = 0; i < 7; i++) write_reg(i[CFG_IDX_W-1:0], pick_par());
		write_reg(REG_ASCERTAIN, (pick_par() << 17) | pick_par());
	endtask

	function automatic obs_t mk(logic [1:0] c, logic s, logic l);
		obs_t o;
		o.obs_code = c;
		o.start_flag = s;
		o.last_flag = l;
		return o;
	endfunction

	// receiver: random stalls, plus one long hold-off in its own process
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (pending_res.size() == 0) begin
					report("unexpected transaction", 64'(res.total_nll), 64'd0);
				end else begin
					res_t w;
					w = pending_res.pop_front();
					if (res.ind_nll !== w.ind_nll)
						report("ind_nll", 64'(res.ind_nll), 64'(w.ind_nll));
					if (res.total_nll !== w.total_nll)
						report("total_nll", 64'(res.total_nll), 64'(w.total_nll));
					if (res.sum_zero !== w.sum_zero)
						report("sum_zero", 64'(res.sum_zero), 64'(w.sum_zero));
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_off) begin
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (res_ready && res_valid) begin
			stall_left <= $urandom_range(0, 7);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		res_t zr;
		zr.ind_nll = NLL_SAT[39:0];
		zr.sum_zero = 1'b1;
		for (int i = 0; i < 7; i++) par_q[i] = 64'(PAR_RESET);
		par_q[REG_ASCERTAIN] = 64'(ASC_RESET);
		alpha_q = '{0, 0, 0};
		expo_q = 0;
		total_q = 0;
		idle_cycles(12);
		arst_n <= 1'b1;
		idle_cycles(2);

		// item before any start: zero vector, sum zero, total takes the saturated nll
		zr.total_nll = NLL_SAT[47:0];
		rows.push_back('{mk(OBS_UNSEEN, 1'b0, 1'b1), 1'b1, zr});
		// start on unseen code loads zero vector
		zr.total_nll = 48'(2 * NLL_SAT);
		rows.push_back('{mk(OBS_UNSEEN, 1'b1, 1'b1), 1'b1, zr});
		rows.push_back('{mk(OBS_NB, 1'b1, 1'b0), 1'b0, '0});
		rows.push_back('{mk(OBS_UNSEEN, 1'b0, 1'b0), 1'b0, '0});
		rows.push_back('{mk(OBS_NA, 1'b0, 1'b0), 1'b0, '0});
		rows.push_back('{mk(OBS_B, 1'b0, 1'b1), 1'b0, '0});
		rows.push_back('{mk(OBS_B, 1'b1, 1'b1), 1'b0, '0});
		rows.push_back('{mk(OBS_NA, 1'b1, 1'b0), 1'b0, '0});
		rows.push_back('{mk(OBS_NB, 1'b0, 1'b1), 1'b0, '0});
		rows.push_back('{mk(OBS_NB, 1'b1, 1'b1), 1'b0, '0});
		foreach (rows[i]) occasion(rows[i].item, rows[i].fixed, rows[i].want);
		settle();

		// extremes: all zero, then all above one (clipped to one)
		for (int i = 0; i < 7; i++) write_reg(i[CFG_IDX_W-1:0], 64'd0);
		write_reg(REG_ASCERTAIN, 64'd0);
		for (int c = 0; c < 4; c++) begin
			occasion(mk(c[1:0], 1'b1, 1'b0), 1'b0, '0);
			occasion(mk(c[1:0], 1'b0, 1'b1), 1'b0, '0);
		end
		settle();
		for (int i = 0; i < 7; i++) write_reg(i[CFG_IDX_W-1:0], 64'h1FFFF);
		write_reg(REG_ASCERTAIN, 64'h3_FFFF_FFFF);
		for (int c = 0; c < 4; c++) occasion(mk(c[1:0], 1'b1, 1'b1), 1'b0, '0);
		settle();

		// back-pressure: long hold while items keep coming
		write_reg(REG_INIT, ONE / 3);
		write_reg(REG_ASCERTAIN, (64'd20000 << 17) | 64'd40000);
		hold_off = 1'b1;
		fork
			begin
				idle_cycles(600);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) occasion(mk(OBS_NA, 1'b1, 1'b1), 1'b0, '0);
		join
		settle();

		// random phases: mostly well-formed histories with random content
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			for (int n = 0; n < 130; n++) begin
				int len;
				if ($urandom_range(0, 9) == 0) begin
					occasion(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))), 1'b0, '0);
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					occasion(mk(2'($urandom_range(1, 3)), 1'b1, len == 1), 1'b0, '0);
					for (int k = 1; k < len; k++)
						occasion(mk(2'($urandom_range(0, 3)), 1'b0, k == len - 1),
							1'b0, '0);
					n += len - 1;
				end
			end
			settle();
		end
		while (pending_res.size() != 0) @(posedge clk);
		idle_cycles(60);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/hfl_pkg.sv
sv/hfl_ctrl.sv
sv/hfl_datapath.sv
sv/hmm_forward_likelihood.sv
sv/hfl_checker.sv
dv/tb.sv
